FILE: rtl/core/rdpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdpc_pkg - shared constants and types for the radix digit palindrome check
// Widths, radix limits and the controller/datapath command and status words.
// ----------------------------------------------------------------------------
package rdpc_pkg;

  // Sizing
  localparam int MAX_DIGITS  = 32;
  localparam int VALUE_WIDTH = 32;
  localparam int IN_W        = 32;
  localparam int RADIX_W     = 5;
  localparam int DIGIT_W     = 4;
  localparam int COUNT_OUT_W = 6;

  // Radix register
  localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
  localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(16);

  // Divider: quotient bits formed per cycle
  localparam int DIV_STEP   = 8;
  localparam int USE_W      = (VALUE_WIDTH < IN_W) ? VALUE_WIDTH : IN_W;
  localparam int DIV_CHUNKS = (USE_W + DIV_STEP - 1) / DIV_STEP;
  localparam int PAD_W      = DIV_CHUNKS * DIV_STEP;
  localparam int CHUNK_W    = (DIV_CHUNKS > 1) ? $clog2(DIV_CHUNKS) : 1;

  // Digit store
  localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
  localparam int ADDR_W = $clog2(MAX_DIGITS);

  typedef struct packed {
    logic load;         // capture value, clear digit count
    logic digit_start;  // clear remainder before a digit
    logic div_en;       // one chunk of the division
    logic div_last;     // final chunk: store digit, bump count
    logic cmp_start;    // reset pair index and symmetry flag
    logic cmp_read;     // read one digit pair
    logic cmp_check;    // compare the pair read
  } rdpc_cmd_t;

  typedef struct packed {
    logic value_zero;
    logic count_full;
    logic pairs_done;
    logic mismatch;
  } rdpc_stat_t;

endpackage

FILE: rtl/core/rdpc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdpc_dp - datapath of the radix digit palindrome check
// Radix register, chunked restoring divider, digit store and pair compare.
// ----------------------------------------------------------------------------
module rdpc_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [rdpc_pkg::RADIX_W-1:0]        cfg_data,
  input  logic [rdpc_pkg::IN_W-1:0]           value_in,
  input  rdpc_pkg::rdpc_cmd_t                 cmd,
  output rdpc_pkg::rdpc_stat_t                stat,
  output logic                                symmetric,
  output logic [rdpc_pkg::COUNT_OUT_W-1:0]    digit_count
);

  logic [rdpc_pkg::RADIX_W-1:0] radix_r;
  logic [rdpc_pkg::RADIX_W-1:0] eff_radix;
  logic [rdpc_pkg::PAD_W-1:0]   value_r;
  logic [rdpc_pkg::PAD_W-1:0]   value_nxt;
  logic [rdpc_pkg::DIGIT_W-1:0] rem_r;
  logic [rdpc_pkg::DIGIT_W-1:0] rem_nxt;
  logic [rdpc_pkg::DIGIT_W:0]   trial;
  logic [rdpc_pkg::DIV_STEP-1:0] quot;
  logic [rdpc_pkg::CNT_W-1:0]   n_r;
  logic [rdpc_pkg::ADDR_W-1:0]  idx_r;
  logic [rdpc_pkg::CNT_W-1:0]   mirror;
  logic                         sym_r;
  logic [rdpc_pkg::DIGIT_W-1:0] rd_a_r;
  logic [rdpc_pkg::DIGIT_W-1:0] rd_b_r;
  logic [rdpc_pkg::DIGIT_W-1:0] digit_mem [rdpc_pkg::MAX_DIGITS];

  // out-of-range radix saturates so every digit fits the store
  always_comb begin
    priority if (radix_r < rdpc_pkg::RADIX_MIN) begin
      eff_radix = rdpc_pkg::RADIX_MIN;
    end else if (radix_r > rdpc_pkg::RADIX_MAX) begin
      eff_radix = rdpc_pkg::RADIX_MAX;
    end else begin
      eff_radix = radix_r;
    end
  end

  // DIV_STEP restoring steps on a narrow remainder; quotient shifts in at the bottom
  always_comb begin
    rem_nxt = rem_r;
    quot    = '0;
    trial   = '0;
    for (int k = rdpc_pkg::DIV_STEP - 1; k >= 0; k--) begin
      trial = {rem_nxt, value_r[rdpc_pkg::PAD_W - rdpc_pkg::DIV_STEP + k]};
      if (trial >= eff_radix) begin
        trial   = trial - eff_radix;
        quot[k] = 1'b1;
      end
      rem_nxt = trial[rdpc_pkg::DIGIT_W-1:0];
    end
    value_nxt = (value_r << rdpc_pkg::DIV_STEP) | rdpc_pkg::PAD_W'(quot);
  end

  assign mirror = n_r - rdpc_pkg::CNT_W'(1) - rdpc_pkg::CNT_W'(idx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= rdpc_pkg::RADIX_RESET;
      n_r     <= '0;
      sym_r   <= 1'b1;
    end else begin
      if (cfg_we) begin
        radix_r <= cfg_data;
      end
      if (cmd.load) begin
        n_r <= '0;
      end else if (cmd.div_last) begin
        n_r <= n_r + rdpc_pkg::CNT_W'(1);
      end
      if (cmd.cmp_start) begin
        sym_r <= 1'b1;
      end else if (cmd.cmp_check && stat.mismatch) begin
        sym_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value_r <= rdpc_pkg::PAD_W'(value_in[rdpc_pkg::USE_W-1:0]);
    end else if (cmd.div_en) begin
      value_r <= value_nxt;
    end
    if (cmd.digit_start) begin
      rem_r <= '0;
    end else if (cmd.div_en) begin
      rem_r <= rem_nxt;
    end
    if (cmd.div_last) begin
      digit_mem[n_r[rdpc_pkg::ADDR_W-1:0]] <= rem_nxt;
    end
    if (cmd.cmp_start) begin
      idx_r <= '0;
    end else if (cmd.cmp_check && !stat.mismatch) begin
      idx_r <= idx_r + rdpc_pkg::ADDR_W'(1);
    end
    if (cmd.cmp_read) begin
      rd_a_r <= digit_mem[idx_r];
      rd_b_r <= digit_mem[mirror[rdpc_pkg::ADDR_W-1:0]];
    end
  end

  assign stat.value_zero = (value_r == '0);
  assign stat.count_full = (n_r == rdpc_pkg::CNT_W'(rdpc_pkg::MAX_DIGITS));
  assign stat.pairs_done = (rdpc_pkg::CNT_W'(idx_r) >= (n_r >> 1));
  assign stat.mismatch   = (rd_a_r != rd_b_r);

  assign symmetric   = sym_r;
  assign digit_count = rdpc_pkg::COUNT_OUT_W'(n_r);

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= rdpc_pkg::CNT_W'(rdpc_pkg::MAX_DIGITS))
    else $error("digit count past store depth");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_en |-> ({1'b0, rem_r} < eff_radix))
    else $error("remainder not below radix");

  a_store_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_last |-> !stat.count_full)
    else $error("digit write with store full");
`endif

endmodule

FILE: rtl/core/rdpc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdpc_ctrl - controller of the radix digit palindrome check
// Sequences digit conversion chunk by chunk, then the pair compare pass.
// ----------------------------------------------------------------------------
module rdpc_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  output logic                 out_valid,
  output rdpc_pkg::rdpc_cmd_t  cmd,
  input  rdpc_pkg::rdpc_stat_t stat
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_CMP_RD,
    ST_CMP_CHK
  } state_t;

  state_t                       state_r, state_nxt;
  logic [rdpc_pkg::CHUNK_W-1:0] chunk_r, chunk_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         last_chunk;

  assign last_chunk = (chunk_r == rdpc_pkg::CHUNK_W'(rdpc_pkg::DIV_CHUNKS - 1));

  always_comb begin
    state_nxt     = state_r;
    chunk_nxt     = chunk_r;
    out_valid_nxt = 1'b0;
    cmd           = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (stat.value_zero || stat.count_full) begin
          cmd.cmp_start = 1'b1;
          state_nxt     = ST_CMP_RD;
        end else begin
          cmd.digit_start = 1'b1;
          chunk_nxt       = '0;
          state_nxt       = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd.div_en = 1'b1;
        if (last_chunk) begin
          cmd.div_last = 1'b1;
          state_nxt    = ST_CHECK;
        end else begin
          chunk_nxt = chunk_r + rdpc_pkg::CHUNK_W'(1);
        end
      end
      ST_CMP_RD: begin
        if (stat.pairs_done) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          cmd.cmp_read = 1'b1;
          state_nxt    = ST_CMP_CHK;
        end
      end
      ST_CMP_CHK: begin
        cmd.cmp_check = 1'b1;
        if (stat.mismatch) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          state_nxt = ST_CMP_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      chunk_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      chunk_r     <= chunk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

`ifndef NO_ASSERTIONS
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ST_IDLE))
    else $error("result strobe outside idle");

  a_accept_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && start) |=> (state_r == ST_CHECK && !out_valid_r))
    else $error("accepted word did not enter conversion");

  a_chunk_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (chunk_r <= rdpc_pkg::CHUNK_W'(rdpc_pkg::DIV_CHUNKS - 1)))
    else $error("chunk counter overrun");
`endif

endmodule

FILE: rtl/core/radix_digit_palindrome_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_digit_palindrome_check - digit palindrome test in a configurable radix
// Converts a value to digits by repeated division and checks their symmetry.
// ----------------------------------------------------------------------------
// Usage:
//  - Input: present in_value and raise start; the word is taken at a clock edge
//    where start is high and busy is low. busy stays high until the result.
//  - Output: out_valid pulses for one cycle with out_symmetric and
//    out_digit_count; the receiver must take it then, it cannot stall.
//  - Config: cfg_radix is written when cfg_valid and cfg_ready are high
//    (cfg_ready is always high); write only while idle. Radix below 2 acts
//    as 2, above 16 as 16. Reset value is 10.
//  - Sequence: each digit takes a check state plus DIV_CHUNKS (4) divider
//    chunks, the divider forming 8 quotient bits per cycle. The compare pass
//    reads one digit pair from the digit store and then compares it, stopping
//    at the first mismatch.
//    The next word may be accepted in the cycle of the result strobe.
//  - Reset (rst_n low, synchronous): controller idle, radix 10, count 0.
// ----------------------------------------------------------------------------
module radix_digit_palindrome_check (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [rdpc_pkg::IN_W-1:0]           in_value,
  output logic                                out_valid,
  output logic                                out_symmetric,
  output logic [rdpc_pkg::COUNT_OUT_W-1:0]    out_digit_count,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rdpc_pkg::RADIX_W-1:0]        cfg_radix
);

  rdpc_pkg::rdpc_cmd_t  cmd;
  rdpc_pkg::rdpc_stat_t stat;

  assign cfg_ready = 1'b1;

  rdpc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .out_valid (out_valid),
    .cmd       (cmd),
    .stat      (stat)
  );

  rdpc_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_data    (cfg_radix),
    .value_in    (in_value),
    .cmd         (cmd),
    .stat        (stat),
    .symmetric   (out_symmetric),
    .digit_count (out_digit_count)
  );

endmodule
